// File: rtl/bstk_pkg.sv
package bstk_pkg;

  localparam int unsigned DefDepth = 128;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned CountW   = 8;

  typedef enum logic [2:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_PEEK,
    CMD_DUP,
    CMD_SWAP,
    CMD_ROT_L,
    CMD_ROT_R,
    CMD_CLEAR
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_OK,
    ERR_OVERFLOW,
    ERR_EMPTY,
    ERR_FEW
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SWAP,
    ST_SWAP2,
    ST_ROT,
    ST_ROT_END,
    ST_PEND
  } state_e;

  typedef struct packed {
    cmd_e                      cmd;
    logic signed [ValueW-1:0]  push_value;
    logic        [CountW-1:0]  rotate_count;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0]  top_value;
    logic                      top_valid;
    logic        [CountW-1:0]  fill_len;
    err_e                      error_code;
  } out_item_t;

endpackage

// File: rtl/bstk_ram.sv
module bstk_ram #(
  parameter int unsigned DEPTH = bstk_pkg::DefDepth,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [bstk_pkg::ValueW-1:0] wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [bstk_pkg::ValueW-1:0] rdata_o
);
  import bstk_pkg::*;

  logic [ValueW-1:0] mem [DEPTH];
  logic [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bounded_stack_with_dup_swap_rotate.sv
// Bounded stack of signed 32-bit words with push, pop, peek, dup, swap, rotate
// and clear. Every accepted command returns one result: the new top (zero when
// empty), a valid flag, the length and an error code; a failing command leaves
// the stack as it was. The entries sit in a single-port-read RAM and the top
// word is also kept in a register. Push, peek, dup, clear, every error case,
// a rotate of fewer than two entries and a pop that empties the stack finish
// in ST_IDLE; any other pop goes on to ST_LOAD, a swap to ST_SWAP, ST_SWAP2,
// and a rotate to ST_ROT, where the sequencer walks the one RAM read port
// address by address, and then ST_ROT_END. The input stalls while a command is
// in progress or its result waits in ST_PEND; a finished result waits in the
// output register, so the next command is taken while it is still held there.
module bounded_stack_with_dup_swap_rotate #(
  parameter int unsigned DEPTH = bstk_pkg::DefDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bstk_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bstk_pkg::out_item_t out_data_o
);
  import bstk_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (FW > CountW) ? FW : CountW;

  state_e state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic signed [ValueW-1:0] top_q, top_d;
  logic signed [ValueW-1:0] hold_q, hold_d;
  err_e err_q, err_d;
  logic [AW-1:0] a_q, a_d;
  logic [AW-1:0] mark_q, mark_d;
  logic [AW-1:0] stop_q, stop_d;
  logic dir_q, dir_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  logic we;
  logic [AW-1:0] waddr;
  logic [ValueW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [ValueW-1:0] rdata;

  logic finish;
  logic load;
  logic out_free;
  logic empty;
  logic full;
  logic [CW-1:0] n_ext;
  logic [CW-1:0] f_ext;
  logic [AW-1:0] f_addr;
  logic [AW-1:0] top_addr;
  logic [AW-1:0] sec_addr;
  logic [AW-1:0] base_addr;
  logic [AW-1:0] a_up;
  logic [AW-1:0] a_dn;
  logic capture;

  bstk_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign empty     = (fill_q == '0);
  assign full      = (fill_q == FW'(DEPTH));
  assign n_ext     = CW'(in_data_i.rotate_count);
  assign f_ext     = CW'(fill_q);
  assign f_addr    = AW'(fill_q);
  assign top_addr  = AW'(fill_q - FW'(1));
  assign sec_addr  = AW'(fill_q - FW'(2));
  assign base_addr = AW'(fill_q - FW'(in_data_i.rotate_count));
  assign a_up      = a_q + AW'(1);
  assign a_dn      = a_q - AW'(1);
  assign capture   = (a_q == mark_q);

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    top_d   = top_q;
    hold_d  = hold_q;
    err_d   = err_q;
    a_d     = a_q;
    mark_d  = mark_q;
    stop_d  = stop_q;
    dir_d   = dir_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = top_q;
    raddr   = '0;
    finish  = 1'b0;
    load    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          err_d = ERR_OK;
          case (in_data_i.cmd)
            CMD_PUSH: begin
              if (full) begin
                err_d = ERR_OVERFLOW;
              end else begin
                we     = 1'b1;
                waddr  = f_addr;
                wdata  = in_data_i.push_value;
                top_d  = in_data_i.push_value;
                fill_d = fill_q + FW'(1);
              end
              finish = 1'b1;
            end
            CMD_POP: begin
              if (empty) begin
                err_d  = ERR_EMPTY;
                finish = 1'b1;
              end else if (fill_q == FW'(1)) begin
                fill_d = '0;
                finish = 1'b1;
              end else begin
                // new top comes from the entry below
                fill_d  = fill_q - FW'(1);
                raddr   = sec_addr;
                state_d = ST_LOAD;
              end
            end
            CMD_PEEK: begin
              if (empty) begin
                err_d = ERR_EMPTY;
              end
              finish = 1'b1;
            end
            CMD_DUP: begin
              if (empty) begin
                err_d = ERR_EMPTY;
              end else if (full) begin
                err_d = ERR_OVERFLOW;
              end else begin
                we     = 1'b1;
                waddr  = f_addr;
                wdata  = top_q;
                fill_d = fill_q + FW'(1);
              end
              finish = 1'b1;
            end
            CMD_SWAP: begin
              if (fill_q < FW'(2)) begin
                err_d  = ERR_FEW;
                finish = 1'b1;
              end else begin
                raddr   = sec_addr;
                state_d = ST_SWAP;
              end
            end
            CMD_ROT_L, CMD_ROT_R: begin
              if (empty) begin
                err_d  = ERR_EMPTY;
                finish = 1'b1;
              end else if (n_ext > f_ext) begin
                err_d  = ERR_FEW;
                finish = 1'b1;
              end else if (n_ext < CW'(2)) begin
                finish = 1'b1;
              end else begin
                dir_d = (in_data_i.cmd == CMD_ROT_L);
                if (in_data_i.cmd == CMD_ROT_L) begin
                  // walk up from the base, each entry moves down one
                  a_d    = base_addr;
                  mark_d = base_addr;
                  stop_d = top_addr;
                end else begin
                  // walk down from below the top, each entry moves up one
                  a_d    = sec_addr;
                  mark_d = sec_addr;
                  stop_d = base_addr;
                end
                raddr   = a_d;
                state_d = ST_ROT;
              end
            end
            CMD_CLEAR: begin
              fill_d = '0;
              finish = 1'b1;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_LOAD: begin
        top_d  = rdata;
        finish = 1'b1;
      end
      ST_SWAP: begin
        we      = 1'b1;
        waddr   = sec_addr;
        wdata   = top_q;
        top_d   = rdata;
        state_d = ST_SWAP2;
      end
      ST_SWAP2: begin
        we     = 1'b1;
        waddr  = top_addr;
        wdata  = top_q;
        finish = 1'b1;
      end
      ST_ROT: begin
        // rdata holds the entry at a_q
        if (capture) begin
          hold_d = rdata;
        end
        if (dir_q) begin
          we    = !capture;
          waddr = a_dn;
        end else begin
          we    = 1'b1;
          waddr = a_up;
        end
        wdata = rdata;
        if (a_q == stop_q) begin
          state_d = ST_ROT_END;
        end else begin
          a_d   = dir_q ? a_up : a_dn;
          raddr = a_d;
        end
      end
      ST_ROT_END: begin
        we     = 1'b1;
        waddr  = stop_q;
        wdata  = dir_q ? hold_q : top_q;
        top_d  = hold_q;
        finish = 1'b1;
      end
      ST_PEND: begin
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish || (state_q == ST_PEND)) begin
      if (out_free) begin
        load    = 1'b1;
        state_d = ST_IDLE;
      end else begin
        state_d = ST_PEND;
      end
    end
  end

  always_comb begin
    out_data_d            = out_data_q;
    out_data_d.top_value  = (fill_d != '0) ? top_d : '0;
    out_data_d.top_valid  = (fill_d != '0);
    out_data_d.fill_len   = CountW'(fill_d);
    out_data_d.error_code = err_d;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      err_q       <= ERR_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    hold_q <= hold_d;
    a_q    <= a_d;
    mark_q <= mark_d;
    stop_q <= stop_d;
    dir_q  <= dir_d;
    if (load) begin
      out_data_q <= out_data_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
